>>> design/pasmu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pasmu_pkg: shared types and helpers of the polynomial add/sub/mul unit
// Opcodes, controller states, the cell control bundle and the 32-bit
// saturation helper used by every coefficient cell.
// ----------------------------------------------------------------------------
package pasmu_pkg;

  // Coefficient width (signed Q16.16) and the widened sum width
  localparam int COEF_W = 32;
  localparam int SUM_W  = 49;

  // Input opcodes; codes 5 to 7 are unused and do nothing
  typedef enum logic [2:0] {
    OP_LOAD_A = 3'd0,
    OP_LOAD_B = 3'd1,
    OP_ADD    = 3'd2,
    OP_SUB    = 3'd3,
    OP_MUL    = 3'd4
  } opcode_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN_AB,
    ST_CHECK,
    ST_MAC,
    ST_DRAIN,
    ST_SCAN_R,
    ST_EMIT,
    ST_ERR
  } state_t;

  // Control broadcast from the sequencer to every cell
  typedef struct packed {
    logic comb_en;    // acc <= sat(a +/- b)
    logic sub;        // select subtract for comb_en
    logic mul_start;  // copy b into the shift lane, clear acc
    logic mul_step;   // multiply broadcast a by lane value, shift lane
    logic acc_en;     // acc <= sat(acc + (prod >>> 16))
  } cell_ctrl_t;

  // Clamp a widened signed sum to the signed 32-bit range
  function automatic logic signed [COEF_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
    logic signed [COEF_W-1:0] r;
    if (v[SUM_W-1:COEF_W-1] == {(SUM_W-COEF_W+1){1'b0}} ||
        v[SUM_W-1:COEF_W-1] == {(SUM_W-COEF_W+1){1'b1}}) begin
      r = v[COEF_W-1:0];
    end else if (v[SUM_W-1]) begin
      r = {1'b1, {(COEF_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(COEF_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> design/pasmu_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pasmu_cell: one coefficient cell
// Holds coefficient k of A and B, a shift-lane copy of B that moves one cell
// up per multiply step, a product register and the result accumulator.
// ----------------------------------------------------------------------------
module pasmu_cell (
  input  wire                          clk,
  input  wire                          rst_n,
  input  pasmu_pkg::cell_ctrl_t        ctrl,
  input  wire                          we_a,
  input  wire                          we_b,
  input  wire  signed [31:0]           ld_value,
  input  wire  signed [31:0]           a_bcast,
  input  wire  signed [31:0]           bw_in,
  output logic signed [31:0]           a_q,
  output logic signed [31:0]           b_q,
  output logic signed [31:0]           bw_q,
  output logic signed [31:0]           acc_q
);

  logic signed [31:0] a_r;
  logic signed [31:0] b_r;
  logic signed [31:0] bw_r;
  logic signed [63:0] prod_r;
  logic signed [31:0] acc_r;
  logic signed [48:0] comb_sum;
  logic signed [48:0] mac_sum;

  // Stored coefficients, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_r <= '0;
      b_r <= '0;
    end else begin
      if (we_a) a_r <= ld_value;
      if (we_b) b_r <= ld_value;
    end
  end

  // Add/subtract and multiply-accumulate sums, widened so they cannot wrap
  always_comb begin
    if (ctrl.sub) begin
      comb_sum = {{17{a_r[31]}}, a_r} - {{17{b_r[31]}}, b_r};
    end else begin
      comb_sum = {{17{a_r[31]}}, a_r} + {{17{b_r[31]}}, b_r};
    end
    mac_sum = {{17{acc_r[31]}}, acc_r} + {prod_r[63], prod_r[63:16]};
  end

  // Shift lane, product and accumulator
  always_ff @(posedge clk) begin
    if (ctrl.mul_start) begin
      bw_r <= b_r;
    end else if (ctrl.mul_step) begin
      bw_r <= bw_in;
    end
    if (ctrl.mul_step) prod_r <= a_bcast * bw_r;
    if (ctrl.mul_start) begin
      acc_r <= '0;
    end else if (ctrl.comb_en) begin
      acc_r <= pasmu_pkg::sat32(comb_sum);
    end else if (ctrl.acc_en) begin
      acc_r <= pasmu_pkg::sat32(mac_sum);
    end
  end

  assign a_q   = a_r;
  assign b_q   = b_r;
  assign bw_q  = bw_r;
  assign acc_q = acc_r;

endmodule
`default_nettype wire

>>> design/polynomial_add_sub_mul_unit_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Sequence (N = MAX_DEGREE+1): a load gives no result; add/sub scans the
// result and then gives N results; multiply scans A and B, checks the degree,
// runs the multiply steps, drains, scans the result, then gives N results.
// A degree error gives one error item. One operation at a time: a new item is
// accepted only while idle, once the last result has been taken.
// Reset: synchronous; A and B clear to zero, sequencer returns to idle.
// ----------------------------------------------------------------------------
// polynomial_add_sub_mul_unit_core: polynomial add/sub/multiply unit
// A row of coefficient cells with per-cell multiply-accumulate; B shifts one
// cell up per step so cell k gathers a[i]*b[k-i] in increasing i.
// ----------------------------------------------------------------------------
module polynomial_add_sub_mul_unit_core #(
  parameter int MAX_DEGREE = 4
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  wire  [2:0]          in_opcode,
  input  wire  [2:0]          in_coeff_index,
  input  wire  signed [31:0]  in_coeff_value,
  output logic                out_valid,
  input  wire                 out_ready,
  output logic [2:0]          out_index,
  output logic signed [31:0]  out_value,
  output logic [2:0]          out_result_degree,
  output logic                out_error,
  output logic                out_last
);

  localparam int N  = MAX_DEGREE + 1;
  localparam int IW = $clog2(N);

  pasmu_pkg::state_t     state_r, state_nxt;
  pasmu_pkg::cell_ctrl_t ctrl;
  logic [IW-1:0]         cnt_r, cnt_nxt;
  logic [IW-1:0]         da_r, db_r, rd_r;
  logic                  acc_en_r;
  logic                  in_xfer, out_xfer, cnt_last, idx_ok, deg_over;

  logic signed [31:0] a_q   [N];
  logic signed [31:0] b_q   [N];
  logic signed [31:0] bw_q  [N];
  logic signed [31:0] acc_q [N];
  logic [N-1:0]       we_a, we_b;

  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;
  assign cnt_last = (cnt_r == IW'(MAX_DEGREE));
  assign idx_ok   = (32'(in_coeff_index) <= 32'(MAX_DEGREE));
  assign deg_over = ({1'b0, da_r} + {1'b0, db_r}) > (IW + 1)'(MAX_DEGREE);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pasmu_pkg::ST_IDLE: begin
        if (in_xfer) begin
          unique case (in_opcode)
            pasmu_pkg::OP_ADD, pasmu_pkg::OP_SUB: state_nxt = pasmu_pkg::ST_SCAN_R;
            pasmu_pkg::OP_MUL:                    state_nxt = pasmu_pkg::ST_SCAN_AB;
            default:                              state_nxt = pasmu_pkg::ST_IDLE;
          endcase
        end
      end
      pasmu_pkg::ST_SCAN_AB: if (cnt_last) state_nxt = pasmu_pkg::ST_CHECK;
      pasmu_pkg::ST_CHECK:   state_nxt = deg_over ? pasmu_pkg::ST_ERR : pasmu_pkg::ST_MAC;
      pasmu_pkg::ST_MAC:     if (cnt_last) state_nxt = pasmu_pkg::ST_DRAIN;
      pasmu_pkg::ST_DRAIN:   state_nxt = pasmu_pkg::ST_SCAN_R;
      pasmu_pkg::ST_SCAN_R:  if (cnt_last) state_nxt = pasmu_pkg::ST_EMIT;
      pasmu_pkg::ST_EMIT:    if (out_xfer && cnt_last) state_nxt = pasmu_pkg::ST_IDLE;
      pasmu_pkg::ST_ERR:     if (out_xfer) state_nxt = pasmu_pkg::ST_IDLE;
      default:               state_nxt = pasmu_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs and step counter
  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    ctrl      = '0;
    ctrl.sub  = (in_opcode == pasmu_pkg::OP_SUB);
    ctrl.acc_en = acc_en_r;
    cnt_nxt   = '0;
    unique case (state_r)
      pasmu_pkg::ST_IDLE: begin
        in_ready       = 1'b1;
        ctrl.comb_en   = in_xfer && (in_opcode == pasmu_pkg::OP_ADD ||
                                     in_opcode == pasmu_pkg::OP_SUB);
        ctrl.mul_start = in_xfer && (in_opcode == pasmu_pkg::OP_MUL);
      end
      pasmu_pkg::ST_SCAN_AB, pasmu_pkg::ST_SCAN_R: begin
        cnt_nxt = cnt_last ? '0 : cnt_r + 1'b1;
      end
      pasmu_pkg::ST_MAC: begin
        ctrl.mul_step = 1'b1;
        cnt_nxt       = cnt_last ? '0 : cnt_r + 1'b1;
      end
      pasmu_pkg::ST_EMIT: begin
        out_valid = 1'b1;
        cnt_nxt   = out_xfer ? (cnt_last ? '0 : cnt_r + 1'b1) : cnt_r;
      end
      pasmu_pkg::ST_ERR: begin
        out_valid = 1'b1;
      end
      default: begin
        cnt_nxt = '0;
      end
    endcase
  end

  // Sequencer registers and degree trackers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= pasmu_pkg::ST_IDLE;
      cnt_r    <= '0;
      acc_en_r <= 1'b0;
      da_r     <= '0;
      db_r     <= '0;
      rd_r     <= '0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      acc_en_r <= ctrl.mul_step;
      if (in_xfer) begin
        da_r <= '0;
        db_r <= '0;
        rd_r <= '0;
      end
      if (state_r == pasmu_pkg::ST_SCAN_AB) begin
        if (a_q[cnt_r] != 32'sd0) da_r <= cnt_r;
        if (b_q[cnt_r] != 32'sd0) db_r <= cnt_r;
      end
      if (state_r == pasmu_pkg::ST_SCAN_R && acc_q[cnt_r] != 32'sd0) rd_r <= cnt_r;
    end
  end

  // Cell row
  for (genvar k = 0; k < N; k++) begin : g_cell
    logic signed [31:0] bw_in;
    if (k == 0) begin : g_head
      assign bw_in = 32'sd0;
    end else begin : g_link
      assign bw_in = bw_q[k-1];
    end
    assign we_a[k] = in_xfer && (in_opcode == pasmu_pkg::OP_LOAD_A) && idx_ok &&
                     (32'(in_coeff_index) == 32'(k));
    assign we_b[k] = in_xfer && (in_opcode == pasmu_pkg::OP_LOAD_B) && idx_ok &&
                     (32'(in_coeff_index) == 32'(k));
    pasmu_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (ctrl),
      .we_a     (we_a[k]),
      .we_b     (we_b[k]),
      .ld_value (in_coeff_value),
      .a_bcast  (a_q[cnt_r]),
      .bw_in    (bw_in),
      .a_q      (a_q[k]),
      .b_q      (b_q[k]),
      .bw_q     (bw_q[k]),
      .acc_q    (acc_q[k])
    );
  end

  // Result payload
  always_comb begin
    if (state_r == pasmu_pkg::ST_ERR) begin
      out_index         = 3'd0;
      out_value         = 32'sd0;
      out_result_degree = 3'd0;
      out_error         = 1'b1;
      out_last          = 1'b1;
    end else begin
      out_index         = 3'(cnt_r);
      out_value         = acc_q[cnt_r];
      out_result_degree = 3'(rd_r);
      out_error         = 1'b0;
      out_last          = cnt_last;
    end
  end

  // Checks
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input accepted while a result is pending");

  a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_error) |-> (out_last && out_value == 32'sd0))
    else $error("degree error result not a single zero item");

  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_error && out_last) |-> (out_index == 3'(MAX_DEGREE)))
    else $error("last marker on wrong coefficient");

  a_back_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_last) |=> in_ready)
    else $error("sequencer not idle after final transfer");

endmodule
`default_nettype wire

>>> sim/polynomial_add_sub_mul_unit_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polynomial_add_sub_mul_unit_core_tb: self-checking bench for the poly unit
// Drives load/add/sub/mul items over a valid/ready channel, predicts every
// result coefficient from a local copy of A and B, and checks each result
// transfer in order. Random idle gaps on both channels, with quiet stretches.
// ----------------------------------------------------------------------------
module polynomial_add_sub_mul_unit_core_tb;

  localparam int MAX_DEGREE = 4;
  localparam int NCOEF      = MAX_DEGREE + 1;
  localparam int RAND_ITEMS = 500;
  localparam int MAX_SHOWN  = 10;
  localparam logic [2:0] OP_FIRST_SPARE = 3'd5;
  localparam logic signed [31:0] COEF_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] COEF_MIN = 32'sh80000000;
  localparam logic signed [31:0] COEF_ONE = 32'sh00010000;

  typedef logic signed [31:0] coeff_vec_t [NCOEF];

  typedef struct packed {
    logic [2:0]         idx;
    logic signed [31:0] value;
    logic [2:0]         degree;
    logic               err;
    logic               last;
  } coeff_result_t;

  // DUT signals
  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [2:0]         in_opcode = '0;
  logic [2:0]         in_coeff_index = '0;
  logic signed [31:0] in_coeff_value = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [2:0]         out_index;
  logic signed [31:0] out_value;
  logic [2:0]         out_result_degree;
  logic               out_error;
  logic               out_last;

  // Bench state
  coeff_vec_t    a_coef = '{default: '0};
  coeff_vec_t    b_coef = '{default: '0};
  coeff_result_t pending_coeffs [$];
  int            mismatch_count = 0;
  bit            quiet_phase = 1'b0;
  bit            ready_taken = 1'b0;
  int            ready_hold = 0;

  polynomial_add_sub_mul_unit_core #(
    .MAX_DEGREE(MAX_DEGREE)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_opcode        (in_opcode),
    .in_coeff_index   (in_coeff_index),
    .in_coeff_value   (in_coeff_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_index        (out_index),
    .out_value        (out_value),
    .out_result_degree(out_result_degree),
    .out_error        (out_error),
    .out_last         (out_last)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Clamp to signed 32-bit range
  function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
    if (v > 64'sh000000007fffffff) return COEF_MAX;
    if (v < -64'sh0000000080000000) return COEF_MIN;
    return v[31:0];
  endfunction

  // Highest index holding a nonzero coefficient, 0 if none
  function automatic int top_nonzero(input coeff_vec_t c);
    for (int d = MAX_DEGREE; d > 0; d--) begin
      if (c[d] != 0) return d;
    end
    return 0;
  endfunction

  // Queue one full result polynomial, index 0 first
  task automatic push_coeffs(input coeff_vec_t r);
    coeff_result_t res;
    int deg;
    deg = top_nonzero(r);
    for (int k = 0; k < NCOEF; k++) begin
      res.idx    = 3'(k);
      res.value  = r[k];
      res.degree = 3'(deg);
      res.err    = 1'b0;
      res.last   = (k == MAX_DEGREE);
      pending_coeffs.push_back(res);
    end
  endtask

  // Update local A/B and queue the coefficients an accepted item produces
  task automatic compute_expected_coeffs(input logic [2:0] op, input logic [2:0] idx,
                                         input logic signed [31:0] val);
    coeff_vec_t         r;
    logic signed [63:0] acc;
    logic signed [63:0] prod;
    int                 da;
    int                 db;
    coeff_result_t      res;
    r = '{default: '0};
    case (op)
      pasmu_pkg::OP_LOAD_A: if (idx <= MAX_DEGREE) a_coef[idx] = val;
      pasmu_pkg::OP_LOAD_B: if (idx <= MAX_DEGREE) b_coef[idx] = val;
      pasmu_pkg::OP_ADD, pasmu_pkg::OP_SUB: begin
        for (int k = 0; k < NCOEF; k++) begin
          acc = a_coef[k];
          acc = (op == pasmu_pkg::OP_ADD) ? acc + b_coef[k] : acc - b_coef[k];
          r[k] = clamp32(acc);
        end
        push_coeffs(r);
      end
      pasmu_pkg::OP_MUL: begin
        da = top_nonzero(a_coef);
        db = top_nonzero(b_coef);
        if (da + db > MAX_DEGREE) begin
          res = '0;
          res.err  = 1'b1;
          res.last = 1'b1;
          pending_coeffs.push_back(res);
        end else begin
          // A outer, B inner; every partial sum saturates
          for (int i = 0; i <= da; i++) begin
            for (int j = 0; j <= db; j++) begin
              prod = a_coef[i];
              prod = prod * b_coef[j];
              acc  = r[i + j];
              acc  = acc + (prod >>> 16);
              r[i + j] = clamp32(acc);
            end
          end
          push_coeffs(r);
        end
      end
      default: ;
    endcase
  endtask

  // One input transfer: idle gap, present, wait for accept, predict
  task automatic send_item(input logic [2:0] op, input logic [2:0] idx,
                           input logic signed [31:0] val);
    int gap;
    gap = quiet_phase ? 0 : $urandom_range(0, 6);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_opcode      <= op;
    in_coeff_index <= idx;
    in_coeff_value <= val;
    do @(posedge clk); while (!in_ready);
    compute_expected_coeffs(op, idx, val);
  endtask

  // Random coefficient with weight on zero, extremes and modest values
  function automatic logic signed [31:0] rand_coeff();
    logic signed [31:0] v;
    case ($urandom_range(0, 7))
      0, 1: v = '0;
      2:    v = $urandom;
      3: begin
        case ($urandom_range(0, 3))
          0:       v = COEF_MAX;
          1:       v = COEF_MIN;
          2:       v = COEF_ONE;
          default: v = -COEF_ONE;
        endcase
      end
      4, 5:    v = $signed($urandom_range(0, 32'h000fffff)) - 32'sh00080000;
      default: v = $signed($urandom_range(0, 32'h01ffffff)) - 32'sh01000000;
    endcase
    return v;
  endfunction

  // Result checker: compare each transfer against the oldest expectation
  always @(posedge clk) begin
    coeff_result_t want;
    if (rst_n && out_valid && out_ready) begin
      ready_taken = 1'b1;
      if (pending_coeffs.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_SHOWN)
          $display("%0t: unexpected result idx=%0d value=%0d deg=%0d err=%0b last=%0b",
                   $time, out_index, out_value, out_result_degree, out_error, out_last);
      end else begin
        want = pending_coeffs.pop_front();
        if (out_index !== want.idx || out_value !== want.value ||
            out_result_degree !== want.degree || out_error !== want.err ||
            out_last !== want.last) begin
          mismatch_count++;
          if (mismatch_count <= MAX_SHOWN)
            $display("%0t: mismatch exp idx=%0d value=%0d deg=%0d err=%0b last=%0b",
                     $time, want.idx, $signed(want.value), want.degree, want.err,
                     want.last, "  got idx=%0d value=%0d deg=%0d err=%0b last=%0b",
                     out_index, out_value, out_result_degree, out_error, out_last);
        end
      end
    end
  end

  // Result side back-pressure: random hold-off drawn after each transfer
  always @(negedge clk) begin
    if (ready_taken) begin
      ready_taken = 1'b0;
      ready_hold  = quiet_phase ? 0 : $urandom_range(0, 6);
    end
    if (ready_hold == 0) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= 1'b0;
      ready_hold--;
    end
  end

  // Both vectors are zero out of reset
  task automatic test_cleared_state();
    send_item(pasmu_pkg::OP_MUL, 3'd0, 32'sd0);
    send_item(pasmu_pkg::OP_ADD, 3'd7, COEF_MAX);
  endtask

  // Out of range load index and spare opcodes leave state untouched
  task automatic test_ignored_items();
    send_item(pasmu_pkg::OP_LOAD_A, 3'd5, COEF_MAX);
    send_item(pasmu_pkg::OP_LOAD_B, 3'd7, COEF_MIN);
    send_item(OP_FIRST_SPARE, 3'd0, $urandom);
    send_item(3'(OP_FIRST_SPARE + 1), 3'd4, $urandom);
    send_item(3'(OP_FIRST_SPARE + 2), 3'd7, $urandom);
    send_item(pasmu_pkg::OP_SUB, 3'd0, 32'sd0);
  endtask

  // Add/sub saturation both ways, cancellation at the top index
  task automatic test_add_sub_saturation();
    send_item(pasmu_pkg::OP_LOAD_A, 3'd0, COEF_MAX);
    send_item(pasmu_pkg::OP_LOAD_B, 3'd0, COEF_MAX);
    send_item(pasmu_pkg::OP_LOAD_A, 3'd1, COEF_MIN);
    send_item(pasmu_pkg::OP_LOAD_B, 3'd1, COEF_MAX);
    send_item(pasmu_pkg::OP_LOAD_A, 3'd4, 32'sd1);
    send_item(pasmu_pkg::OP_LOAD_B, 3'd4, -32'sd1);
    send_item(pasmu_pkg::OP_ADD, 3'd0, 32'sd0);
    send_item(pasmu_pkg::OP_SUB, 3'd0, 32'sd0);
  endtask

  // Sum of degrees above the maximum gives a single error transfer
  task automatic test_mul_degree_error();
    send_item(pasmu_pkg::OP_MUL, 3'd0, 32'sd0);
  endtask

  // Saturation order inside a coefficient and floor of negative products
  task automatic test_mul_saturation_and_floor();
    send_item(pasmu_pkg::OP_LOAD_A, 3'd4, 32'sd0);
    send_item(pasmu_pkg::OP_LOAD_B, 3'd4, 32'sd0);
    send_item(pasmu_pkg::OP_MUL, 3'd0, 32'sd0);
    send_item(pasmu_pkg::OP_LOAD_A, 3'd0, -32'sd1);
    send_item(pasmu_pkg::OP_LOAD_B, 3'd0, 32'sd1);
    send_item(pasmu_pkg::OP_MUL, 3'd0, 32'sd0);
  endtask

  // Mostly loads and operations with random content, some ignored noise
  task automatic test_random_traffic();
    int                 counted;
    int                 pick;
    logic [2:0]         idx;
    logic signed [31:0] val;
    counted = 0;
    while (counted < RAND_ITEMS) begin
      if (counted % 40 == 0) quiet_phase = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        idx = 3'($urandom_range(0, MAX_DEGREE));
        val = rand_coeff();
        // keep high terms often zero so multiplies fit the degree limit
        if (idx >= 2 && $urandom_range(0, 1) == 0) val = '0;
        send_item((pick < 28) ? pasmu_pkg::OP_LOAD_A : pasmu_pkg::OP_LOAD_B, idx, val);
        counted++;
      end else if (pick < 90) begin
        case ($urandom_range(0, 2))
          0:       send_item(pasmu_pkg::OP_ADD, 3'($urandom), $urandom);
          1:       send_item(pasmu_pkg::OP_SUB, 3'($urandom), $urandom);
          default: send_item(pasmu_pkg::OP_MUL, 3'($urandom), $urandom);
        endcase
        counted++;
      end else if (pick < 95) begin
        send_item(3'(OP_FIRST_SPARE + $urandom_range(0, 2)), 3'($urandom), $urandom);
      end else begin
        send_item(($urandom_range(0, 1) == 0) ? pasmu_pkg::OP_LOAD_A : pasmu_pkg::OP_LOAD_B,
                  3'($urandom_range(MAX_DEGREE + 1, 7)), $urandom);
      end
    end
    quiet_phase = 1'b0;
  endtask

  // Main sequence
  initial begin
    int waited;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_cleared_state();
    test_ignored_items();
    test_add_sub_saturation();
    test_mul_degree_error();
    test_mul_saturation_and_floor();
    test_random_traffic();

    @(negedge clk);
    in_valid <= 1'b0;

    // drain, then watch for stray transfers
    waited = 0;
    while (pending_coeffs.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (60) @(posedge clk);

    if (mismatch_count == 0 && pending_coeffs.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
